// File: rtl/sssd_pkg.sv
// ----------------------------------------------------------------------------
// Shift-subtract divider package
// The default width constant and the control bundle that drives the row of divider cells.
// ----------------------------------------------------------------------------
package sssd_pkg;

    // Default operand width of the divider.
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // Control broadcast from the sequencer to every bit cell.
    typedef struct packed {
        logic load;  // capture a new dividend and divisor bit, clear the remainder
        logic step;  // perform one shift-and-subtract iteration
        logic sub;   // this iteration keeps the difference (quotient bit is one)
    } t_cell_ctrl;

endpackage

// File: rtl/sssd_cell.sv
// ----------------------------------------------------------------------------
// Shift-subtract divider bit cell
// One bit slice of remainder, quotient and divisor with its borrow stage.
// ----------------------------------------------------------------------------
module sssd_cell (
    input  logic                 i_clk,
    input  sssd_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_num,
    input  logic                 i_den,
    input  logic                 i_rem_in,
    input  logic                 i_quo_in,
    input  logic                 i_borrow_in,
    output logic                 o_rem,
    output logic                 o_quo,
    output logic                 o_borrow
);
    import sssd_pkg::*;

    logic r_rem;
    logic r_quo;
    logic r_den;
    logic n_rem;
    logic n_quo;
    logic n_den;
    logic w_diff;

    // One bit of (shifted remainder - divisor).
    always_comb begin
        w_diff   = i_rem_in ^ r_den ^ i_borrow_in;
        o_borrow = (~i_rem_in & r_den) | (~(i_rem_in ^ r_den) & i_borrow_in);
    end

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_den = r_den;
        if (i_ctrl.load) begin
            n_rem = 1'b0;
            n_quo = i_num;
            n_den = i_den;
        end else if (i_ctrl.step) begin
            n_rem = i_ctrl.sub ? w_diff : i_rem_in;
            n_quo = i_quo_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

// File: rtl/shift_subtract_integer_divider.sv
// The operands load at the accepting edge; the row of bit cells then iterates,
// one quotient bit per cycle, and the finishing state applies the sign and fills
// the output register once that register is free.
// A new transaction is taken only when idle or in the finishing state, so
// divisions do not overlap.
// Reset (i_rst_n, synchronous, active low) empties the sequencer and output
// register; the bit cells hold data only and are not reset.
// ----------------------------------------------------------------------------
// Shift-subtract integer divider
// Restoring radix-2 divider, unsigned or signed, built from a row of bit cells.
// ----------------------------------------------------------------------------
module shift_subtract_integer_divider #(
    parameter int unsigned DATA_WIDTH = sssd_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic                  o_divide_by_zero
);
    import sssd_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_neg;
    logic                r_dbz;
    logic                r_out_valid;
    logic [DATA_WIDTH-1:0] r_quotient;
    logic                r_out_dbz;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_neg_a;
    logic                  w_neg_b;
    logic [DATA_WIDTH-1:0] w_mag_a;
    logic [DATA_WIDTH-1:0] w_mag_b;
    logic [DATA_WIDTH-1:0] w_rem;
    logic [DATA_WIDTH-1:0] w_quo;
    logic [DATA_WIDTH-1:0] w_borrow;
    logic [DATA_WIDTH-1:0] w_rem_sh;
    logic [DATA_WIDTH-1:0] w_quo_sh;
    logic [DATA_WIDTH-1:0] w_borrow_in;
    logic                  w_sub;
    t_cell_ctrl            w_ctrl;

    // The output register frees up when it is empty or is being drained this cycle.
    assign w_out_free = !r_out_valid || i_out_ready;

    // A new transaction enters when idle, or in the finishing cycle when the
    // current result can move into the output register at the same edge.
    assign o_in_ready = (r_state == ST_IDLE) || ((r_state == ST_DONE) && w_out_free);
    assign w_accept   = i_in_valid && o_in_ready;

    // Signed mode divides magnitudes; the sign is restored when the result leaves.
    assign w_neg_a = i_op && i_dividend[DATA_WIDTH-1];
    assign w_neg_b = i_op && i_divisor[DATA_WIDTH-1];
    assign w_mag_a = w_neg_a ? ((~i_dividend) + DATA_WIDTH'(1)) : i_dividend;
    assign w_mag_b = w_neg_b ? ((~i_divisor) + DATA_WIDTH'(1)) : i_divisor;

    // Neighbor wiring of the cell row. The remainder shifts left taking the top
    // dividend bit from the quotient register, while the quotient register shifts
    // left taking in the new quotient bit. The borrow ripples up from bit zero.
    assign w_rem_sh    = {w_rem[DATA_WIDTH-2:0], w_quo[DATA_WIDTH-1]};
    assign w_quo_sh    = {w_quo[DATA_WIDTH-2:0], w_sub};
    assign w_borrow_in = {w_borrow[DATA_WIDTH-2:0], 1'b0};

    // Subtract when the bit shifted out of the remainder was set (the shifted
    // value is then surely above the divisor) or the subtraction did not borrow.
    assign w_sub = w_rem[DATA_WIDTH-1] | ~w_borrow[DATA_WIDTH-1];

    always_comb begin
        w_ctrl.load = w_accept;
        w_ctrl.step = (r_state == ST_RUN);
        w_ctrl.sub  = w_sub;
    end

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        sssd_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_num       (w_mag_a[g]),
            .i_den       (w_mag_b[g]),
            .i_rem_in    (w_rem_sh[g]),
            .i_quo_in    (w_quo_sh[g]),
            .i_borrow_in (w_borrow_in[g]),
            .o_rem       (w_rem[g]),
            .o_quo       (w_quo[g]),
            .o_borrow    (w_borrow[g])
        );
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A finished division fills the output register whenever it is free;
            // otherwise a drained result empties it.
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_neg <= w_neg_a ^ w_neg_b;
                r_dbz <= (i_divisor == '0);
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_RUN;
                        r_cnt   <= '0;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DATA_WIDTH - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_out_dbz   <= r_dbz;
                        if (r_dbz) begin
                            r_quotient <= '1;
                        end else if (r_neg) begin
                            r_quotient <= (~w_quo) + DATA_WIDTH'(1);
                        end else begin
                            r_quotient <= w_quo;
                        end
                        if (w_accept) begin
                            r_state <= ST_RUN;
                            r_cnt   <= '0;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_quotient       = r_quotient;
    assign o_divide_by_zero = r_out_dbz;

`ifndef SYNTH
    // An accepted transaction always starts iterating at the next edge.
    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_RUN) && (r_cnt == '0))
        else $error("accepted transaction did not start the iteration");

    // The load clears the whole remainder before the first iteration.
    a_rem_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && (r_cnt == '0)) |-> (w_rem == '0))
        else $error("remainder not cleared at start of division");

    // A zero divisor result always carries the all-ones quotient.
    a_dbz_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_by_zero) |-> (&o_quotient))
        else $error("divide by zero result without all-ones quotient");

    // A new result only appears out of the finishing state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result appeared outside the finishing state");
`endif

endmodule
